// ===== hw/rtl/rgb_to_hsv_converter_top_defines.svh =====
// Assertion macros for the converter checker.
`ifndef RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhc: check failed");

`endif

// ===== hw/rtl/rhc_pkg.sv =====
// Shared constants for the RGB to HSV converter.
package rhc_pkg;
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int CH_W    = 8;
  localparam int HUE_W   = 15;
  localparam int PCT_W   = 7;
  localparam int TOTAL_W = 17;   // d * hue degrees, below 2^17
  localparam int SDIV_W  = 15;   // 100 * spread
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int HUE_FULL_DEF = 360 << HUE_FRAC_BITS_DEF;
endpackage

// ===== hw/rtl/rhc_front.sv =====
// Entry stage: max, min, spread, hue numerator, saturation dividend, value.
module rhc_front #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int NW = rhc_pkg::TOTAL_W + HUE_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rhc_pkg::CH_W-1:0]   red,
  input  logic [rhc_pkg::CH_W-1:0]   green,
  input  logic [rhc_pkg::CH_W-1:0]   blue,
  output logic                       valid_r,
  output logic [NW-1:0]              rem_h_r,
  output logic [rhc_pkg::SDIV_W-1:0] rem_s_r,
  output logic [rhc_pkg::CH_W-1:0]   d_r,
  output logic [rhc_pkg::CH_W-1:0]   hi_r,
  output logic [rhc_pkg::PCT_W-1:0]  val_r
);
  logic [7:0]         hi, lo, d;
  logic signed [8:0]  num;
  logic [8:0]         off;
  logic [16:0]        offd;
  logic signed [18:0] tot;
  logic [15:0]        vx;
  logic [16:0]        vq;

  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    d = hi - lo;
    // red wins a tie, then green
    if (hi == red) begin
      num = $signed({1'b0, green}) - $signed({1'b0, blue});
      off = 9'd360;
    end else if (hi == green) begin
      num = $signed({1'b0, blue}) - $signed({1'b0, red});
      off = 9'd120;
    end else begin
      num = $signed({1'b0, red}) - $signed({1'b0, green});
      off = 9'd240;
    end
    offd = 17'(off) * 17'(d);
    tot  = 19'(num) * 19'sd60 + $signed({2'b00, offd});
    vx   = 16'(hi) * 16'd100;
    // divide by 255: (x + x/256 + 1) / 256
    vq   = (17'(vx) + 17'(vx >> 8) + 17'd1) >> 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_h_r <= (NW'(tot[16:0]) << HUE_FRAC_BITS) + NW'(d >> 1);
      rem_s_r <= 15'(d) * 15'd100;
      d_r     <= d;
      hi_r    <= hi;
      val_r   <= vq[6:0];
    end
  end
endmodule

// ===== hw/rtl/rhc_cell.sv =====
// One divider cell: settles one hue quotient bit and, low down, one saturation bit.
module rhc_cell #(
  parameter int NW  = rhc_pkg::TOTAL_W + rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int QW  = 9 + rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int BIT = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       valid_i,
  input  logic [NW-1:0]              rem_h_i,
  input  logic [rhc_pkg::SDIV_W-1:0] rem_s_i,
  input  logic [QW-1:0]              q_h_i,
  input  logic [rhc_pkg::PCT_W-1:0]  q_s_i,
  input  logic [rhc_pkg::CH_W-1:0]   d_i,
  input  logic [rhc_pkg::CH_W-1:0]   hi_i,
  input  logic [rhc_pkg::PCT_W-1:0]  val_i,
  output logic                       valid_o,
  output logic [NW-1:0]              rem_h_o,
  output logic [rhc_pkg::SDIV_W-1:0] rem_s_o,
  output logic [QW-1:0]              q_h_o,
  output logic [rhc_pkg::PCT_W-1:0]  q_s_o,
  output logic [rhc_pkg::CH_W-1:0]   d_o,
  output logic [rhc_pkg::CH_W-1:0]   hi_o,
  output logic [rhc_pkg::PCT_W-1:0]  val_o
);
  logic [NW-1:0]              dsh;
  logic [rhc_pkg::SDIV_W-1:0] ssh;
  logic [NW-1:0]              rh_n;
  logic [rhc_pkg::SDIV_W-1:0] rs_n;
  logic [QW-1:0]              qh_n;
  logic [rhc_pkg::PCT_W-1:0]  qs_n;

  always_comb begin
    dsh  = NW'(d_i) << BIT;
    rh_n = rem_h_i;
    qh_n = q_h_i;
    if (rem_h_i >= dsh) begin
      rh_n = rem_h_i - dsh;
      qh_n[BIT] = 1'b1;
    end
    ssh  = rhc_pkg::SDIV_W'(hi_i) << BIT;
    rs_n = rem_s_i;
    qs_n = q_s_i;
    if (BIT < rhc_pkg::PCT_W && rem_s_i >= ssh) begin
      rs_n = rem_s_i - ssh;
      qs_n[BIT % rhc_pkg::PCT_W] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_h_o <= rh_n;
      rem_s_o <= rs_n;
      q_h_o   <= qh_n;
      q_s_o   <= qs_n;
      d_o     <= d_i;
      hi_o    <= hi_i;
      val_o   <= val_i;
    end
  end
endmodule

// ===== hw/rtl/rgb_to_hsv_converter_top.sv =====
// Top level of the RGB to HSV converter: entry stage, divider cell chain, output.
// Converts one 8-bit RGB pixel per clock into hue (degrees, fixed point with
// HUE_FRAC_BITS fraction bits, rounded to nearest, wrapped below 360),
// saturation (floor 100*spread/max) and value (floor 100*max/255). A pixel is
// taken every cycle while the output side keeps up. The pipeline is one entry
// stage, then one divider cell per hue quotient bit, each cell a
// compare-and-subtract. The whole chain advances together, so a stall at
// out_tready holds every stage.
module rgb_to_hsv_converter_top #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rhc_pkg::IN_TDATA_W-1:0]  in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rhc_pkg::OUT_TDATA_W-1:0] out_tdata   // hue[14:0], saturation[21:15],
                                                      // brightness[28:22], zero[31:29]
);
  localparam int NW = rhc_pkg::TOTAL_W + HUE_FRAC_BITS;
  localparam int QW = 9 + HUE_FRAC_BITS;   // quotient stays below 421 degrees
  localparam int FULL = 360 << HUE_FRAC_BITS;

  logic en;
  logic                       v    [QW+1];
  logic [NW-1:0]              rh   [QW+1];
  logic [rhc_pkg::SDIV_W-1:0] rs   [QW+1];
  logic [QW-1:0]              qh   [QW+1];
  logic [rhc_pkg::PCT_W-1:0]  qs   [QW+1];
  logic [rhc_pkg::CH_W-1:0]   dd   [QW+1];
  logic [rhc_pkg::CH_W-1:0]   hh   [QW+1];
  logic [rhc_pkg::PCT_W-1:0]  vv   [QW+1];
  logic [QW-1:0]              hue_w;
  logic [rhc_pkg::HUE_W-1:0]  hue;
  logic [rhc_pkg::PCT_W-1:0]  sat;

  // advance the whole chain unless the last item is stalled
  assign en        = !(v[QW] && !out_tready);
  assign in_tready = en;

  rhc_front #(.HUE_FRAC_BITS(HUE_FRAC_BITS), .NW(NW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .red(in_tdata[7:0]), .green(in_tdata[15:8]), .blue(in_tdata[23:16]),
    .valid_r(v[0]), .rem_h_r(rh[0]), .rem_s_r(rs[0]), .d_r(dd[0]),
    .hi_r(hh[0]), .val_r(vv[0])
  );
  assign qh[0] = '0;
  assign qs[0] = '0;

  // one cell per hue bit, most significant first
  for (genvar i = 0; i < QW; i++) begin : g_cell
    rhc_cell #(.NW(NW), .QW(QW), .BIT(QW-1-i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(v[i]), .rem_h_i(rh[i]), .rem_s_i(rs[i]), .q_h_i(qh[i]),
      .q_s_i(qs[i]), .d_i(dd[i]), .hi_i(hh[i]), .val_i(vv[i]),
      .valid_o(v[i+1]), .rem_h_o(rh[i+1]), .rem_s_o(rs[i+1]), .q_h_o(qh[i+1]),
      .q_s_o(qs[i+1]), .d_o(dd[i+1]), .hi_o(hh[i+1]), .val_o(vv[i+1])
    );
  end

  always_comb begin
    // wrap 360 and above back into range; grey pixels have hue 0
    hue_w = qh[QW];
    if (hue_w >= QW'(FULL)) hue_w = hue_w - QW'(FULL);
    if (dd[QW] == '0) hue_w = '0;
    hue = rhc_pkg::HUE_W'(hue_w);
    // black pixel: saturation 0
    sat = (hh[QW] == '0) ? '0 : qs[QW];
  end

  assign out_tvalid = v[QW];
  assign out_tdata  = {3'b000, vv[QW], sat, hue};
endmodule

// ===== hw/rtl/rhc_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`include "rgb_to_hsv_converter_top_defines.svh"
module rhc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [rhc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rhc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  `RHC_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RHC_ASSERT_NOW(a_flow, !out_tvalid || out_tready, in_tready)
  `RHC_ASSERT_NOW(a_hue, out_tvalid, out_tdata[14:0] < 15'(rhc_pkg::HUE_FULL_DEF))
  `RHC_ASSERT_NOW(a_pct, out_tvalid, out_tdata[21:15] <= 7'd100 && out_tdata[28:22] <= 7'd100)
endmodule

bind rgb_to_hsv_converter_top rhc_checker u_rhc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
